// ----- hdl/gcd_pkg.sv -----
// Shared constants, types and helper functions for the great-circle distance unit.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package gcd_pkg;

  localparam int ANGLE_FRAC_BITS   = 16;
  localparam int CORDIC_ITERATIONS = 24;
  localparam int TABLE_LEN         = 32;
  localparam int CORDIC_ITER = (CORDIC_ITERATIONS < TABLE_LEN) ? CORDIC_ITERATIONS : TABLE_LEN;
  localparam int SHIFT_W     = $clog2(TABLE_LEN);

  localparam int LAT_W    = 24;
  localparam int LON_W    = 25;
  localparam int DIST_W   = 32;
  localparam int RADIUS_W = 16;
  localparam int Q_FRAC   = 30;
  localparam int CV_W     = 34;
  localparam int T_W      = 32;
  localparam int ANG_W    = CV_W - 1;
  localparam int DIST_SH  = Q_FRAC - 16;

  localparam int PADDR_W   = 3;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_RADIUS = '0;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd6371;

  localparam logic [31:0] PI_Q30       = 32'd3373259426;
  localparam logic [30:0] HALF_PI_Q30  = 31'd1686629713;
  localparam logic [29:0] CORDIC_K_Q30 = 30'd652032874;

  localparam longint DEG90  = longint'(90) << ANGLE_FRAC_BITS;
  localparam longint DEG180 = longint'(180) << ANGLE_FRAC_BITS;
  localparam longint DEG360 = longint'(360) << ANGLE_FRAC_BITS;
  localparam longint Q_ONE  = longint'(1) << Q_FRAC;

  // degrees to radians: reciprocal estimate, then one compare and correct
  localparam int     MAG_W    = $clog2(DEG90 + 1);
  localparam int     RECIP_SH = MAG_W;
  localparam longint RECIP_K  = (longint'(PI_Q30) << RECIP_SH) / DEG180;
  localparam int     RECIP_W  = $clog2(RECIP_K + 1);
  localparam int     REM_W    = $clog2(2 * DEG180);
  localparam int     RADQ_W   = 32;

  localparam int D2R_STAGES  = 3;
  localparam int SQRT_STAGES = 32;
  localparam int SQ_W        = 64;
  localparam int PIPE_DEPTH  = 2 + D2R_STAGES + CORDIC_ITER + 3 + 1 + SQRT_STAGES + 1
                               + CORDIC_ITER + 1;

  typedef logic signed [CV_W-1:0] cv_t;

  typedef struct packed {
    cv_t x;
    cv_t y;
    cv_t z;
  } cordic_vec_t;

  typedef struct packed {
    logic [SQ_W-1:0] v;
    logic [SQ_W-1:0] r;
  } sqrt_state_t;

  function automatic logic [29:0] atan_q30(input logic [SHIFT_W-1:0] idx);
    logic [29:0] a;
    case (idx)
      5'd0:    a = 30'd843314856;
      5'd1:    a = 30'd497837829;
      5'd2:    a = 30'd263043836;
      5'd3:    a = 30'd133525158;
      5'd4:    a = 30'd67021686;
      5'd5:    a = 30'd33543515;
      5'd6:    a = 30'd16775850;
      5'd7:    a = 30'd8388437;
      5'd8:    a = 30'd4194282;
      5'd9:    a = 30'd2097149;
      5'd10:   a = 30'd1048575;
      5'd11:   a = 30'd524287;
      5'd12:   a = 30'd262143;
      5'd13:   a = 30'd131071;
      5'd14:   a = 30'd65535;
      5'd15:   a = 30'd32767;
      5'd16:   a = 30'd16383;
      5'd17:   a = 30'd8191;
      5'd18:   a = 30'd4095;
      5'd19:   a = 30'd2047;
      5'd20:   a = 30'd1023;
      5'd21:   a = 30'd511;
      5'd22:   a = 30'd255;
      5'd23:   a = 30'd127;
      5'd24:   a = 30'd63;
      5'd25:   a = 30'd31;
      5'd26:   a = 30'd15;
      5'd27:   a = 30'd8;
      5'd28:   a = 30'd4;
      5'd29:   a = 30'd2;
      5'd30:   a = 30'd1;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

  // q30 product, rounded half up
  function automatic cv_t mul_q30(input cv_t a, input cv_t b);
    logic signed [2*CV_W-1:0] p;
    p = (2*CV_W)'(a) * (2*CV_W)'(b) + (2*CV_W)'(longint'(1) << (Q_FRAC - 1));
    return cv_t'(p >>> Q_FRAC);
  endfunction

endpackage

// ----- hdl/gcd_if.sv -----
// Valid/ready channel interfaces for coordinate beats and distance beats.
// Depends on gcd_pkg for field widths.
`timescale 1ns / 1ps

interface gcd_in_if import gcd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [LAT_W-1:0] first_latitude;
  logic signed [LON_W-1:0] first_longitude;
  logic signed [LAT_W-1:0] second_latitude;
  logic signed [LON_W-1:0] second_longitude;

  modport source (output valid, first_latitude, first_longitude, second_latitude,
                  second_longitude, input ready);
  modport sink (input valid, first_latitude, first_longitude, second_latitude,
                second_longitude, output ready);
endinterface

interface gcd_out_if import gcd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance_km;

  modport source (output valid, distance_km, input ready);
  modport sink (input valid, distance_km, output ready);
endinterface

// ----- hdl/gcd_deg2rad.sv -----
// Three-stage degrees-to-radians converter with round half away from zero.
// Depends on gcd_pkg.
`timescale 1ns / 1ps

module gcd_deg2rad
  import gcd_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [MAG_W-1:0] mag,
  input  logic             sign,
  output cv_t              rad
);

  localparam int P_W  = MAG_W + 32;
  localparam int E_W  = MAG_W + RECIP_W;
  localparam int N_W  = P_W + 1;

  logic [P_W-1:0]    p;
  logic [RADQ_W-1:0] q0;
  logic [RADQ_W-1:0] q1;
  logic [REM_W-1:0]  rem;
  logic              sg1;
  logic              sg2;
  logic [E_W-1:0]    est;
  logic [N_W-1:0]    rem_full;
  cv_t               qf;

  always_comb begin
    est      = E_W'(mag) * E_W'(RECIP_K) + E_W'(longint'(1) << (RECIP_SH - 1));
    rem_full = N_W'(p) + N_W'(DEG180 / 2) - N_W'(q0) * N_W'(DEG180);
    qf       = cv_t'(q1) + cv_t'(rem >= REM_W'(DEG180));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p   <= P_W'(mag) * P_W'(PI_Q30);
      q0  <= RADQ_W'(est >> RECIP_SH);
      sg1 <= sign;
      rem <= rem_full[REM_W-1:0];
      q1  <= q0;
      sg2 <= sg1;
      rad <= sg2 ? -qf : qf;
    end
  end

endmodule

// ----- hdl/gcd_cordic_cell.sv -----
// One CORDIC micro-rotation cell, rotation or vectoring mode, registered output.
// Depends on gcd_pkg.
`timescale 1ns / 1ps

module gcd_cordic_cell
  import gcd_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic               vectoring,
  input  logic [SHIFT_W-1:0] shift,
  input  cordic_vec_t        din,
  output cordic_vec_t        dout
);

  cv_t  dx;
  cv_t  dy;
  cv_t  da;
  logic cw;

  always_comb begin
    dx = din.y >>> shift;
    dy = din.x >>> shift;
    da = cv_t'(atan_q30(shift));
    cw = vectoring ? (din.y > 0) : (din.z < 0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (cw) begin
        dout.x <= din.x + dx;
        dout.y <= din.y - dy;
        dout.z <= din.z + da;
      end else begin
        dout.x <= din.x - dx;
        dout.y <= din.y + dy;
        dout.z <= din.z - da;
      end
    end
  end

endmodule

// ----- hdl/gcd_sqrt_cell.sv -----
// One digit step of the restoring integer square root, registered output.
// Depends on gcd_pkg.
`timescale 1ns / 1ps

module gcd_sqrt_cell
  import gcd_pkg::*;
(
  input  logic            clk,
  input  logic            en,
  input  logic [SQ_W-1:0] bit_val,
  input  sqrt_state_t     din,
  output sqrt_state_t     dout
);

  logic [SQ_W-1:0] trial;

  assign trial = din.r + bit_val;

  always_ff @(posedge clk) begin
    if (en) begin
      if (din.v >= trial) begin
        dout.v <= din.v - trial;
        dout.r <= (din.r >> 1) + bit_val;
      end else begin
        dout.v <= din.v;
        dout.r <= din.r >> 1;
      end
    end
  end

endmodule

// ----- hdl/great_circle_distance_unit.sv -----
// Great-circle distance by the spherical law of cosines, fully pipelined.
// Depends on gcd_pkg, gcd_if, gcd_deg2rad, gcd_cordic_cell and gcd_sqrt_cell.
//
// in_ch carries one coordinate pair per beat (degrees times 65536, signed);
// out_ch returns the distance in km times 65536, one beat per input beat, in
// order. The radius register sits at APB address 0; the user must write it only
// while idle; the block does not enforce this. A new beat is taken every cycle
// unless the output is stalled. The path is two prep stages, a 3-stage radian
// conversion, a row of 24 sin/cos CORDIC cells (three lanes), three product
// stages, 32 square-root cells, a 24-cell arccosine CORDIC row and the radius
// multiply. The whole row advances together: in_ch.ready is high whenever the
// output register is empty or being taken, so a stalled receiver freezes every
// stage and nothing is dropped. Reset clears the valid bits and loads radius 6371.
`timescale 1ns / 1ps

module great_circle_distance_unit
  import gcd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  gcd_in_if.sink             in_ch,
  gcd_out_if.source          out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int NEG_DLY = D2R_STAGES + CORDIC_ITER;
  localparam int M_W     = ANG_W + RADIUS_W;

  function automatic logic signed [LAT_W-1:0] clamp_lat(input logic signed [LAT_W-1:0] v);
    logic signed [LAT_W-1:0] r;
    if (longint'(v) > DEG90) r = LAT_W'(DEG90);
    else if (longint'(v) < -DEG90) r = LAT_W'(-DEG90);
    else r = v;
    return r;
  endfunction

  function automatic logic signed [LON_W-1:0] clamp_lon(input logic signed [LON_W-1:0] v);
    logic signed [LON_W-1:0] r;
    if (longint'(v) > DEG180) r = LON_W'(DEG180);
    else if (longint'(v) < -DEG180) r = LON_W'(-DEG180);
    else r = v;
    return r;
  endfunction

  logic                    en;
  logic [RADIUS_W-1:0]     radius;
  logic [PIPE_DEPTH-1:0]   vld;
  logic                    out_valid;
  logic [DIST_W-1:0]       distance;

  // prep stages
  logic signed [LAT_W-1:0] lat1_c;
  logic signed [LON_W-1:0] lon1_c;
  logic signed [LAT_W-1:0] lat2_c;
  logic signed [LON_W-1:0] lon2_c;
  logic signed [LON_W:0]   dlon;
  logic [LON_W-1:0]        adlon;
  logic [LON_W-1:0]        fold;
  logic [MAG_W-1:0]        mag1;
  logic [MAG_W-1:0]        mag2;
  logic [MAG_W-1:0]        maga;
  logic                    sg1;
  logic                    sg2;
  logic                    neg0;
  logic [MAG_W-1:0]        mag1_n;
  logic [MAG_W-1:0]        mag2_n;
  logic [MAG_W-1:0]        maga_n;
  logic                    neg_n;
  logic                    neg_d [NEG_DLY];

  cv_t                     rad [3];
  cordic_vec_t             sc [3][CORDIC_ITER+1];

  // products
  cv_t                     p_ss;
  cv_t                     p_cc;
  cv_t                     p_cd;
  cv_t                     p_s12;
  cv_t                     p_m;
  logic signed [CV_W:0]    csum;
  logic signed [T_W-1:0]   t_next;
  logic signed [T_W-1:0]   t;
  logic signed [T_W:0]     om_s;
  logic signed [T_W:0]     op_s;
  logic [SQ_W-1:0]         q_p;
  logic signed [T_W-1:0]   tq;
  logic signed [T_W-1:0]   t_d [SQRT_STAGES];
  sqrt_state_t             sq [SQRT_STAGES+1];

  cordic_vec_t             vc [CORDIC_ITER+1];
  cordic_vec_t             vc_in;
  cordic_vec_t             vc0_next;
  cv_t                     root;

  logic [ANG_W-1:0]        ang;
  logic [M_W-1:0]          m_prod;
  logic [M_W:0]            dsum;
  logic [M_W-DIST_SH:0]    dq;

  assign en           = !out_valid || out_ch.ready;
  assign in_ch.ready  = en;
  assign out_ch.valid = out_valid;
  assign out_ch.distance_km = distance;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1:2] == REG_RADIUS) ? 32'(radius) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_RADIUS) begin
      radius <= pwdata[RADIUS_W-1:0];
    end
  end

  // beat tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[PIPE_DEPTH-2:0], in_ch.valid};
      out_valid <= vld[PIPE_DEPTH-1];
    end
  end

  // longitude difference folding
  always_comb begin
    dlon  = (LON_W+1)'(lon2_c) - (LON_W+1)'(lon1_c);
    adlon = (dlon < 0) ? LON_W'(-dlon) : LON_W'(dlon);
    fold  = (adlon > LON_W'(DEG180)) ? LON_W'(DEG360) - adlon : adlon;
    if (fold > LON_W'(DEG90)) begin
      maga_n = MAG_W'(LON_W'(DEG180) - fold);
      neg_n  = 1'b1;
    end else begin
      maga_n = MAG_W'(fold);
      neg_n  = 1'b0;
    end
    mag1_n = (lat1_c < 0) ? MAG_W'(-(LAT_W+1)'(lat1_c)) : MAG_W'(lat1_c);
    mag2_n = (lat2_c < 0) ? MAG_W'(-(LAT_W+1)'(lat2_c)) : MAG_W'(lat2_c);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lat1_c <= clamp_lat(in_ch.first_latitude);
      lon1_c <= clamp_lon(in_ch.first_longitude);
      lat2_c <= clamp_lat(in_ch.second_latitude);
      lon2_c <= clamp_lon(in_ch.second_longitude);
      mag1   <= mag1_n;
      mag2   <= mag2_n;
      maga   <= maga_n;
      sg1    <= lat1_c < 0;
      sg2    <= lat2_c < 0;
      neg0   <= neg_n;
      neg_d[0] <= neg0;
      for (int i = 1; i < NEG_DLY; i++) neg_d[i] <= neg_d[i-1];
    end
  end

  gcd_deg2rad u_d2r_lat1 (.clk(clk), .en(en), .mag(mag1), .sign(sg1),  .rad(rad[0]));
  gcd_deg2rad u_d2r_lat2 (.clk(clk), .en(en), .mag(mag2), .sign(sg2),  .rad(rad[1]));
  gcd_deg2rad u_d2r_dlon (.clk(clk), .en(en), .mag(maga), .sign(1'b0), .rad(rad[2]));

  // sin/cos rows, three lanes
  for (genvar l = 0; l < 3; l++) begin : g_sc_lane
    assign sc[l][0] = '{x: cv_t'(CORDIC_K_Q30), y: '0, z: rad[l]};
    for (genvar k = 0; k < CORDIC_ITER; k++) begin : g_sc_cell
      gcd_cordic_cell u_cell (
        .clk       (clk),
        .en        (en),
        .vectoring (1'b0),
        .shift     (SHIFT_W'(k)),
        .din       (sc[l][k]),
        .dout      (sc[l][k+1])
      );
    end
  end

  // c = s1 s2 + c1 c2 cd, clamped
  always_comb begin
    csum = (CV_W+1)'(p_s12) + (CV_W+1)'(p_m);
    if (csum > (CV_W+1)'(Q_ONE)) t_next = T_W'(Q_ONE);
    else if (csum < -(CV_W+1)'(Q_ONE)) t_next = T_W'(-Q_ONE);
    else t_next = T_W'(csum);
    om_s = (T_W+1)'(Q_ONE) - (T_W+1)'(t);
    op_s = (T_W+1)'(Q_ONE) + (T_W+1)'(t);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_ss  <= mul_q30(sc[0][CORDIC_ITER].y, sc[1][CORDIC_ITER].y);
      p_cc  <= mul_q30(sc[0][CORDIC_ITER].x, sc[1][CORDIC_ITER].x);
      p_cd  <= neg_d[NEG_DLY-1] ? -sc[2][CORDIC_ITER].x : sc[2][CORDIC_ITER].x;
      p_s12 <= p_ss;
      p_m   <= mul_q30(p_cc, p_cd);
      t     <= t_next;
      q_p   <= SQ_W'(om_s[T_W-1:0]) * SQ_W'(op_s[T_W-1:0]);
      tq    <= t;
      t_d[0] <= tq;
      for (int i = 1; i < SQRT_STAGES; i++) t_d[i] <= t_d[i-1];
    end
  end

  // square root row
  assign sq[0] = '{v: q_p, r: '0};
  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
    gcd_sqrt_cell u_cell (
      .clk     (clk),
      .en      (en),
      .bit_val (SQ_W'(1) << (2 * (SQRT_STAGES - 1 - k))),
      .din     (sq[k]),
      .dout    (sq[k+1])
    );
  end

  // arccosine: vector (c, s), pre-rotated when c is negative
  always_comb begin
    root = cv_t'(sq[SQRT_STAGES].r[T_W-1:0]);
    if (t_d[SQRT_STAGES-1] < 0) begin
      vc0_next.x = root;
      vc0_next.y = -cv_t'(t_d[SQRT_STAGES-1]);
      vc0_next.z = cv_t'(HALF_PI_Q30);
    end else begin
      vc0_next.x = cv_t'(t_d[SQRT_STAGES-1]);
      vc0_next.y = root;
      vc0_next.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vc_in <= vc0_next;
    end
  end

  assign vc[0] = vc_in;

  for (genvar k = 0; k < CORDIC_ITER; k++) begin : g_vec
    gcd_cordic_cell u_cell (
      .clk       (clk),
      .en        (en),
      .vectoring (1'b1),
      .shift     (SHIFT_W'(k)),
      .din       (vc[k]),
      .dout      (vc[k+1])
    );
  end

  // scale by radius, round and saturate
  always_comb begin
    ang  = (vc[CORDIC_ITER].z < 0) ? '0 : ANG_W'(vc[CORDIC_ITER].z);
    dsum = (M_W+1)'(m_prod) + (M_W+1)'(longint'(1) << (DIST_SH - 1));
    dq   = dsum[M_W:DIST_SH];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_prod   <= M_W'(ang) * M_W'(radius);
      distance <= (|dq[M_W-DIST_SH:DIST_W]) ? '1 : dq[DIST_W-1:0];
    end
  end

endmodule

// ----- hdl/gcd_checker.sv -----
// Port-level assertions for the great-circle distance unit, bound to the top level.
// Depends on gcd_pkg and great_circle_distance_unit.
`timescale 1ns / 1ps

module gcd_checker
  import gcd_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [PADDR_W-1:0] paddr,
  input logic [31:0]        pwdata,
  input logic [31:0]        prdata,
  input logic               pready
);

  // no beat survives reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // stalled beat stays
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  // an empty output stage never blocks the input
  a_ready: assert property (@(posedge clk) disable iff (rst) !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // radius write reads back
  a_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_RADIUS
    |=> paddr[PADDR_W-1:2] != REG_RADIUS || prdata == 32'($past(pwdata[RADIUS_W-1:0])))
    else $error("radius readback mismatch");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind great_circle_distance_unit gcd_checker u_gcd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata),
  .pready    (pready)
);

// ----- tb/sv/tb_great_circle_distance_unit.sv -----
// Testbench for the great-circle distance unit: directed and random coordinate pairs,
// checked beat by beat against a bit-accurate cordic predictor, with radius changes.
// Depends on gcd_pkg, gcd_if and great_circle_distance_unit.
`timescale 1ns / 1ps

module tb_great_circle_distance_unit;
  import gcd_pkg::*;

  localparam longint LAT_MAX = 5898240;
  localparam longint LON_MAX = 11796480;
  localparam int LATENCY = 92;

  typedef struct {
    longint lat1;
    longint lon1;
    longint lat2;
    longint lon2;
    longint known;  // -1 when the predictor decides
  } pair_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  gcd_in_if in_ch ();
  gcd_out_if out_ch ();

  great_circle_distance_unit uut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  longint radius_km = 6371;
  longint dist_queue[$];
  int errors = 0;
  int out_wait = 0;
  bit long_hold = 1'b0;
  longint arctan_tab[32] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
    131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
    127, 63, 31, 15, 8, 4, 2, 1, 0};

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return floor_shift(a * b + (longint'(1) << 29), 30);
  endfunction

  function automatic longint to_radians(longint deg);
    longint mag;
    longint r;
    mag = deg < 0 ? -deg : deg;
    r = (mag * longint'(PI_Q30) + DEG180 / 2) / DEG180;
    return deg < 0 ? -r : r;
  endfunction

  task automatic rotate(input longint ang, output longint s, output longint c);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    x = longint'(CORDIC_K_Q30);
    y = 0;
    z = ang;
    for (int i = 0; i < CORDIC_ITER; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_tab[i];
      end else begin
        x += dx; y -= dy; z += arctan_tab[i];
      end
    end
    s = y;
    c = x;
  endtask

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = longint'(1) << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint arc_cosine(longint c);
    longint x;
    longint y;
    longint z;
    longint t;
    longint dx;
    longint dy;
    x = c;
    y = int_sqrt(longint'((Q_ONE - c) * (Q_ONE + c)));
    z = 0;
    if (x < 0) begin
      t = x; x = y; y = -t; z = longint'(HALF_PI_Q30);
    end
    for (int i = 0; i < CORDIC_ITER; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += arctan_tab[i];
      end else begin
        x -= dx; y += dy; z -= arctan_tab[i];
      end
    end
    return z < 0 ? 0 : z;
  endfunction

  function automatic longint clip(longint v, longint lim);
    return v < -lim ? -lim : (v > lim ? lim : v);
  endfunction

  task automatic predict_distance(input pair_row_t p, output longint distance);
    longint la1, lo1, la2, lo2, a, s1, c1, s2, c2, sd, cd, cs, ang;
    bit flip;
    la1 = clip(p.lat1, DEG90);
    lo1 = clip(p.lon1, DEG180);
    la2 = clip(p.lat2, DEG90);
    lo2 = clip(p.lon2, DEG180);
    flip = 1'b0;
    a = lo2 - lo1;
    if (a < 0) a = -a;
    if (a > DEG180) a = DEG360 - a;
    if (a > DEG90) begin
      a = DEG180 - a;
      flip = 1'b1;
    end
    rotate(to_radians(la1), s1, c1);
    rotate(to_radians(la2), s2, c2);
    rotate(to_radians(a), sd, cd);
    if (flip) cd = -cd;
    cs = clip(qmul(s1, s2) + qmul(qmul(c1, c2), cd), Q_ONE);
    ang = arc_cosine(cs);
    distance = (ang * radius_km + (longint'(1) << 13)) >>> 14;
    if (distance > 64'hFFFF_FFFF) distance = 64'hFFFF_FFFF;
  endtask

  task automatic write_radius(input longint value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(REG_RADIUS) << 2;
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    radius_km = value;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (dist_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic send_pair(input pair_row_t p, input bit idle);
    longint d;
    int gap;
    gap = idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    predict_distance(p, d);
    if (p.known >= 0) d = p.known;
    in_ch.valid <= 1'b1;
    in_ch.first_latitude <= LAT_W'(p.lat1);
    in_ch.first_longitude <= LON_W'(p.lon1);
    in_ch.second_latitude <= LAT_W'(p.lat2);
    in_ch.second_longitude <= LON_W'(p.lon2);
    do @(posedge clk); while (!in_ch.ready);
    dist_queue.push_back(d);
  endtask

  function automatic longint raw_field(int w);
    longint v;
    v = longint'({$urandom, $urandom}) & ((longint'(1) << w) - 1);
    if (v[w-1]) v -= longint'(1) << w;
    return v;
  endfunction

  function automatic pair_row_t random_pair();
    pair_row_t p;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      p.lat1 = raw_field(LAT_W); p.lon1 = raw_field(LON_W);
      p.lat2 = raw_field(LAT_W); p.lon2 = raw_field(LON_W);
    end else begin
      p.lat1 = longint'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX;
      p.lon1 = longint'($urandom_range(0, 2 * LON_MAX)) - LON_MAX;
      p.lat2 = longint'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX;
      p.lon2 = longint'($urandom_range(0, 2 * LON_MAX)) - LON_MAX;
      if (mode == 1) begin
        p.lat2 = clip(p.lat1 + longint'($urandom_range(0, 200)) - 100, LAT_MAX);
        p.lon2 = clip(p.lon1 + longint'($urandom_range(0, 200)) - 100, LON_MAX);
      end else if (mode == 2) begin
        p.lat2 = -p.lat1;
        p.lon2 = p.lon1 > 0 ? p.lon1 - LON_MAX : p.lon1 + LON_MAX;
      end
    end
    p.known = -1;
    return p;
  endfunction

  pair_row_t directed_rows[] = '{
    '{0, 0, 0, 0, -1},
    '{LAT_MAX, 0, LAT_MAX, 0, -1},
    '{LAT_MAX, 0, -LAT_MAX, 0, -1},
    '{0, 0, 0, LON_MAX, -1},
    '{0, -LON_MAX, 0, LON_MAX, -1},
    '{0, 0, 0, 90 * 65536, -1},
    '{0, 0, 0, 91 * 65536, -1},
    '{0, -100 * 65536, 0, 100 * 65536, -1},
    '{-8388608, -16777216, 8388607, 16777215, -1},
    '{8388607, 16777215, -8388608, -16777216, -1},
    '{LAT_MAX + 1, 0, -LAT_MAX - 1, LON_MAX + 1, -1},
    '{1, 0, 0, 0, -1},
    '{0, 0, 1, 1, -1},
    '{-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX, -1},
    '{45 * 65536, 0, -45 * 65536, LON_MAX, -1},
    '{30 * 65536, 10 * 65536, 30 * 65536, 10 * 65536 + 1, -1},
    '{-1, -1, 1, 1, -1},
    '{5461, 12345, -77777, -4000000, -1}
  };

  longint radii[] = '{65535, 1, 0, 40000};

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      out_wait = $urandom_range(0, 6);
    end else if (out_wait > 0) begin
      out_wait--;
    end
    out_ch.ready <= !rst && !long_hold && out_wait == 0;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (dist_queue.size() == 0) begin
        $error("distance_km beat with nothing expected: actual %0d", out_ch.distance_km);
        errors++;
      end else begin
        longint want;
        want = dist_queue.pop_front();
        if (longint'(out_ch.distance_km) != want) begin
          $error("distance_km mismatch: expected %0d actual %0d", want, out_ch.distance_km);
          errors++;
        end
      end
    end
  end

  initial begin
    wait (!rst);
    repeat (300) @(posedge clk);
    long_hold = 1'b1;
    repeat (400) @(posedge clk);
    long_hold = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.first_latitude = '0;
    in_ch.first_longitude = '0;
    in_ch.second_latitude = '0;
    in_ch.second_longitude = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) send_pair(directed_rows[i], 1'b0);
    drain();
    for (int i = 0; i < 300; i++) send_pair(random_pair(), i % 40 > 20);
    drain();
    foreach (radii[r]) begin
      write_radius(radii[r]);
      for (int i = 0; i < 40; i++) send_pair(random_pair(), i % 2 == 1);
      // antipodal pair: zero radius gives zero, the largest radius saturates
      send_pair('{LAT_MAX, 0, -LAT_MAX, 0,
                  radii[r] == 0 ? 0 : (radii[r] == 65535 ? 4294967295 : -1)}, 1'b0);
      drain();
    end
    write_radius(6371);
    for (int i = 0; i < 430; i++) send_pair(random_pair(), i % 50 > 15);
    drain();
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
